// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the track velocity block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define NTV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies another property at the same edge.
`define NTV_IMPLY(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Checks that a condition implies another property at the next edge.
`define NTV_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== sv/ntv_pkg.sv =====
// Package with the constants, codes and payload types of the track velocity block.
`default_nettype none
package ntv_pkg;

   localparam int CAMERAS     = 8;
   localparam int MAX_OBJECTS = 64;

   localparam int SLOTS  = CAMERAS + 1;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CSEL_W = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
   localparam int IDX_W  = $clog2(MAX_OBJECTS);
   localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
   localparam int DEPTH  = SLOTS * MAX_OBJECTS;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam int TS_W   = 48;
   localparam int NUM_W  = 36;
   localparam int LANES  = 3;

   localparam logic [19:0] US_PER_S = 20'd1000000;
   localparam logic [35:0] VEL_MAX_MAG = 36'd8388607;
   localparam logic [35:0] VEL_MIN_MAG = 36'd8388608;
   localparam logic signed [23:0] VEL_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] VEL_MIN = 24'sh800000;

   // Object kind codes.
   localparam logic [1:0] KIND_BALL   = 2'd0;
   localparam logic [1:0] KIND_YELLOW = 2'd1;
   localparam logic [1:0] KIND_BLUE   = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic signed [5:0] BALL_ID     = -6'sd1;
   localparam logic [5:0]        BLUE_OFFSET = 6'd16;

   // Register indexes.
   localparam logic REG_BALL_RADIUS = 1'b0;
   localparam logic REG_BOT_HEIGHT  = 1'b1;

   typedef struct packed {
      logic [2:0]         camera_index;
      logic [1:0]         object_kind;
      logic [3:0]         bot_number;
      logic               has_object;
      logic [47:0]        timestamp_us;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic               z_given;
      logic signed [15:0] z_pos;
      logic signed [15:0] orientation;
      logic [15:0]        confidence;
      logic               last_of_frame;
   } req_type;

   typedef struct packed {
      logic signed [5:0]  object_id;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
      logic signed [15:0] out_orientation;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic signed [23:0] vel_z;
      logic signed [23:0] vel_turn;
      logic [15:0]        out_confidence;
      logic               matched;
      logic               rate_fault;
   } rsp_type;

   typedef struct packed {
      logic signed [5:0]  id;
      logic [47:0]        ts;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [15:0] w;
   } entry_type;

endpackage
`default_nettype wire

// ===== sv/nearest_track_velocity.sv =====
// Top level of the nearest neighbor track association block with velocity output.
//
//  Channel | Direction | Handshake          | Moves
//  req     | in        | req_valid/ready    | one detection transaction
//  rsp     | out       | rsp_valid/ready    | one tracked object transaction
//  csr     | in/out    | psel/penable/pready| register writes and reads
//
// An item is scanned against the camera's previous entries after its acceptance; the
// scan reads one entry per cycle and drains a two-stage compare pipeline. A matched
// item with a positive time step then has its differences scaled and runs the divider,
// which retires one quotient bit per cycle. Empty items are accepted without a scan.
// Reset is synchronous; the memory needs no clearing
// because only entries below a count are read. A commit swaps slot pointers.
// A stalled result waits in the output register; the next item is accepted meanwhile.
`default_nettype none
`include "assert_macros.svh"
module nearest_track_velocity
   import ntv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_payload,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;

   // Configuration registers.
   logic [9:0] radius_ff, height_ff;
   logic       csr_wr;
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;
   assign prdata = (paddr[2] == REG_BOT_HEIGHT) ? {22'd0, height_ff} : {22'd0, radius_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 10'd21;
         height_ff <= 10'd150;
      end else if (csr_wr) begin
         if (paddr[2] == REG_BALL_RADIUS) radius_ff <= pwdata[9:0];
         else                             height_ff <= pwdata[9:0];
      end
   end

   // Slot pointers and counts: each camera owns a slot, one slot holds the open frame.
   logic [SLOT_W-1:0] slot_ff [CAMERAS];
   logic [SLOT_W-1:0] free_ff;
   logic [CNT_W-1:0]  pcnt_ff [CAMERAS];
   logic [CNT_W-1:0]  fcnt_ff;

   // Latched item.
   logic [2:0]         cam_ff;
   logic               ball_ff, last_ff;
   logic signed [5:0]  id_ff;
   logic [47:0]        ts_ff;
   logic signed [15:0] x_ff, y_ff, z_ff, w_ff;
   logic [15:0]        conf_ff;

   logic accept, item_ok, commit;
   logic [2:0] commit_cam;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign item_ok   = req_payload.has_object & (req_payload.object_kind != KIND_NONE);

   // Scan pipeline.
   logic [CNT_W-1:0]  idx_ff, n_ff;
   logic              v1_ff, v2_ff, issue;
   logic [117:0]      rd_ff;
   logic [ADDR_W-1:0] raddr, waddr;
   logic              we;
   entry_type         wdata, rd_e;
   logic [117:0]      mem [DEPTH];

   logic [33:0]        sqx_ff, sqy_ff, sqz_ff;
   logic               hit_ff;
   entry_type          e2_ff;
   logic signed [16:0] dx1, dy1, dz1;
   logic signed [33:0] px, py, pz;
   logic [35:0]        dsum;

   logic        best_v_ff;
   logic [35:0] bestd_ff;
   entry_type   best_ff;

   assign issue = (state_ff == ST_SCAN) && (idx_ff != n_ff);
   assign raddr = ADDR_W'(slot_ff[CSEL_W'(cam_ff)] * MAX_OBJECTS) + ADDR_W'(idx_ff);
   assign rd_e  = entry_type'(rd_ff);

   // Entry memory, one read and one write port.
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (issue) rd_ff <= mem[raddr];
   end

   // Squared distance of a fetched entry.
   always_comb begin
      dx1  = 17'(x_ff) - 17'(rd_e.x);
      dy1  = 17'(y_ff) - 17'(rd_e.y);
      dz1  = ball_ff ? (17'(z_ff) - 17'(rd_e.z)) : 17'sd0;
      px   = dx1 * dx1;
      py   = dy1 * dy1;
      pz   = dz1 * dz1;
      dsum = 36'(sqx_ff) + 36'(sqy_ff) + 36'(sqz_ff);
   end

   // Divider lanes: x, y and z for balls or heading for robots.
   logic signed [16:0] diff [LANES];
   logic [NUM_W-1:0]   num_ff [LANES];
   logic [48:0]        rem_ff [LANES];
   logic               neg_ff [LANES];
   logic [5:0]         dcnt_ff;
   logic [47:0]        dt_ff;
   logic [47:0]        dt_now;
   logic [48:0]        rsh [LANES];
   logic               qb  [LANES];
   logic signed [23:0] vel [LANES];
   logic               fault_ff;

   assign dt_now = ts_ff - best_ff.ts;

   always_comb begin
      diff[0] = 17'(x_ff) - 17'(best_ff.x);
      diff[1] = 17'(y_ff) - 17'(best_ff.y);
      diff[2] = ball_ff ? (17'(z_ff) - 17'(best_ff.z)) : (17'(w_ff) - 17'(best_ff.w));
      for (int k = 0; k < LANES; k++) begin
         rsh[k] = {rem_ff[k][47:0], num_ff[k][NUM_W-1]};
         qb[k]  = (rsh[k] >= {1'b0, dt_ff});
         if (!best_v_ff || fault_ff) begin
            vel[k] = 24'sd0;
         end else if (neg_ff[k]) begin
            vel[k] = (num_ff[k] > VEL_MIN_MAG) ? VEL_MIN : -$signed(24'(num_ff[k]));
         end else begin
            vel[k] = (num_ff[k] > VEL_MAX_MAG) ? VEL_MAX : $signed(24'(num_ff[k]));
         end
      end
   end

   // Output register and frame store.
   logic    out_free, finish;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish   = (state_ff == ST_DONE) && out_free;
   assign we       = finish && (fcnt_ff < CNT_W'(MAX_OBJECTS));
   assign waddr    = ADDR_W'(free_ff * MAX_OBJECTS) + ADDR_W'(fcnt_ff[IDX_W-1:0]);
   assign wdata    = '{id: id_ff, ts: ts_ff, x: x_ff, y: y_ff, z: z_ff, w: w_ff};
   assign commit   = (accept && !item_ok && req_payload.last_of_frame) || (finish && last_ff);
   assign commit_cam = (state_ff == ST_IDLE) ? req_payload.camera_index : cam_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && item_ok) state_in = ST_SCAN;
         ST_SCAN: begin
            if (idx_ff == n_ff && !v1_ff && !v2_ff) begin
               state_in = (best_v_ff && (ts_ff > best_ff.ts)) ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  if (dcnt_ff == 6'(NUM_W - 1)) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int c = 0; c < CAMERAS; c++) begin
            slot_ff[c] <= SLOT_W'(c);
            pcnt_ff[c] <= '0;
         end
         free_ff      <= SLOT_W'(CAMERAS);
         fcnt_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         if (finish)         rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (commit) begin
            if (32'(commit_cam) < CAMERAS) begin
               slot_ff[CSEL_W'(commit_cam)] <= free_ff;
               free_ff                      <= slot_ff[CSEL_W'(commit_cam)];
               pcnt_ff[CSEL_W'(commit_cam)] <= we ? fcnt_ff + 1'b1 : fcnt_ff;
            end
            fcnt_ff <= '0;
         end else if (we) begin
            fcnt_ff <= fcnt_ff + 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept && item_ok) begin
         cam_ff  <= req_payload.camera_index;
         ball_ff <= (req_payload.object_kind == KIND_BALL);
         last_ff <= req_payload.last_of_frame;
         ts_ff   <= req_payload.timestamp_us;
         x_ff    <= req_payload.x_pos;
         y_ff    <= req_payload.y_pos;
         conf_ff <= req_payload.confidence;
         if (req_payload.object_kind == KIND_BALL) begin
            id_ff <= BALL_ID;
            w_ff  <= 16'sd0;
            z_ff  <= req_payload.z_given ? req_payload.z_pos : $signed({6'd0, radius_ff});
         end else begin
            id_ff <= $signed({2'b00, req_payload.bot_number}
                     + ((req_payload.object_kind == KIND_BLUE) ? BLUE_OFFSET : 6'd0));
            w_ff  <= req_payload.orientation;
            z_ff  <= req_payload.z_given ? req_payload.z_pos : $signed({6'd0, height_ff});
         end
         idx_ff    <= '0;
         n_ff      <= (32'(req_payload.camera_index) < CAMERAS)
                      ? pcnt_ff[CSEL_W'(req_payload.camera_index)] : '0;
         best_v_ff <= 1'b0;
      end
      if (issue) idx_ff <= idx_ff + 1'b1;
      // Stage two: squares and id match.
      if (v1_ff) begin
         sqx_ff <= 34'(px);
         sqy_ff <= 34'(py);
         sqz_ff <= 34'(pz);
         hit_ff <= (rd_e.id == id_ff);
         e2_ff  <= rd_e;
      end
      // Stage three: keep the nearest, later entries win ties.
      if (v2_ff && hit_ff && (!best_v_ff || dsum <= bestd_ff)) begin
         best_v_ff <= 1'b1;
         bestd_ff  <= dsum;
         best_ff   <= e2_ff;
      end
      if (state_ff == ST_SCAN) fault_ff <= best_v_ff && !(ts_ff > best_ff.ts);
      // Scale differences by microseconds per second before dividing.
      if (state_ff == ST_MUL) begin
         dt_ff   <= dt_now;
         dcnt_ff <= '0;
         for (int k = 0; k < LANES; k++) begin
            neg_ff[k] <= diff[k][16];
            num_ff[k] <= NUM_W'((diff[k][16] ? 17'(-diff[k]) : 17'(diff[k])) * US_PER_S);
            rem_ff[k] <= '0;
         end
      end
      // Restoring division, one quotient bit per cycle in each lane.
      if (state_ff == ST_DIV) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         for (int k = 0; k < LANES; k++) begin
            rem_ff[k] <= qb[k] ? (rsh[k] - {1'b0, dt_ff}) : rsh[k];
            num_ff[k] <= {num_ff[k][NUM_W-2:0], qb[k]};
         end
      end
      if (finish) begin
         rsp_ff.object_id       <= id_ff;
         rsp_ff.out_x           <= x_ff;
         rsp_ff.out_y           <= y_ff;
         rsp_ff.out_z           <= z_ff;
         rsp_ff.out_orientation <= w_ff;
         rsp_ff.vel_x           <= vel[0];
         rsp_ff.vel_y           <= vel[1];
         rsp_ff.vel_z           <= ball_ff ? vel[2] : 24'sd0;
         rsp_ff.vel_turn        <= ball_ff ? 24'sd0 : vel[2];
         rsp_ff.out_confidence  <= conf_ff;
         rsp_ff.matched         <= best_v_ff;
         rsp_ff.rate_fault      <= best_v_ff && fault_ff;
      end
   end

   `NTV_ASSERT(a_fcnt_range, fcnt_ff <= CNT_W'(MAX_OBJECTS), "frame count beyond table size")
   `NTV_IMPLY(a_scan_bound, state_ff == ST_SCAN, idx_ff <= n_ff, "scan index past entry count")
   `NTV_NEXT(a_finish_out, finish, rsp_valid_ff, "finished item left no result")
   `NTV_IMPLY(a_pipe_scan, v2_ff || v1_ff, state_ff == ST_SCAN, "scan pipeline busy outside scan")

endmodule
`default_nettype wire
